### rtl/bts_pkg.sv
// shared types, constants and helpers of the barycentric texture sampler
package bts_pkg;

  // input operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEXCOORD_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEXCOORD_B = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEXCOORD_C = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 3'd7;

  localparam int CFG_W    = 64;
  localparam int VTX_W    = 63;
  localparam int COORD_W  = 21;
  localparam int TC_W     = 32;
  localparam int SIZE_W   = 9;
  localparam int TEXEL_W  = 24;

  // square root unit
  localparam int ROOT_IN_W  = 62;
  localparam int ROOT_REG_W = 63;
  localparam int ROOT_OUT_W = 32;
  localparam int ROOT_STEPS = 32;

  // status of the square root unit
  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

  // one signed Q10.10 component of a packed vertex
  function automatic logic signed [COORD_W-1:0] vtx_comp(input logic [VTX_W-1:0] v,
                                                         input logic [1:0] j);
    logic signed [COORD_W-1:0] r;
    case (j)
      2'd0:    r = v[20:0];
      2'd1:    r = v[41:21];
      default: r = v[62:42];
    endcase
    return r;
  endfunction

endpackage

### rtl/bts_texmem.sv
// texel memory, one write port and one registered read port
module bts_texmem #(
  parameter int Depth = 65536,
  parameter int AddrW = 16
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [bts_pkg::TEXEL_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [bts_pkg::TEXEL_W-1:0] rdata_o
);
  import bts_pkg::*;

  logic [TEXEL_W-1:0] mem_q [Depth];
  logic [TEXEL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bts_isqrt.sv
// bit-serial floor square root, two radicand bits per cycle
module bts_isqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bts_pkg::ROOT_IN_W-1:0]  radicand_i,
  output bts_pkg::root_stat_t            stat_o,
  output logic [bts_pkg::ROOT_OUT_W-1:0] root_o
);
  import bts_pkg::*;

  logic                  busy_q, done_q;
  logic [4:0]            step_q;
  logic [ROOT_REG_W-1:0] n_q, res_q, bit_q;
  logic [ROOT_REG_W-1:0] trial;
  logic                  take;

  assign trial = res_q + bit_q;
  assign take  = n_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == 5'(ROOT_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      n_q   <= ROOT_REG_W'(radicand_i);
      res_q <= '0;
      bit_q <= {1'b1, {(ROOT_REG_W-1){1'b0}}};
    end else if (busy_q) begin
      if (take) begin
        n_q   <= n_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = res_q[ROOT_OUT_W-1:0];

endmodule

### rtl/barycentric_texture_sampler.sv
// top level: texel store, triangle registers and the query sequencer
//
// channel | dir | handshake              | payload
// cfg     | in  | cfg_we_i               | cfg_idx_i, cfg_wdata_i
// in      | in  | in_valid_i / in_ready_o| op_i, texel_*, *_in_i, point_*_i
// out     | out | out_valid_o/out_ready_i| *_out_o, degenerate_o
//
// a texel write beat never produces an output beat
// a query steps through the cross products, the scaling shifts, three square
//   sums and three roots (the root unit dominates), three weight divisions,
//   the blend, the wrap steps, one fold, one memory read and one output load
// a degenerate triangle reads every in-use texel once through the single
//   memory read port
// reset clears control and config registers; datapath and texels stay undefined
// a waiting output beat does not stop the next input beat from being taken
module barycentric_texture_sampler #(
  parameter int TEX_DIM = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bts_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic [7:0]                        texel_col_i,
  input  logic [7:0]                        texel_row_i,
  input  logic [7:0]                        red_in_i,
  input  logic [7:0]                        green_in_i,
  input  logic [7:0]                        blue_in_i,
  input  logic signed [bts_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [bts_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [bts_pkg::COORD_W-1:0] point_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [7:0]                        red_out_o,
  output logic [7:0]                        green_out_o,
  output logic [7:0]                        blue_out_o,
  output logic                              degenerate_o
);
  import bts_pkg::*;

  localparam int Depth = TEX_DIM * TEX_DIM;
  localparam int AW    = $clog2(Depth);
  localparam logic [AW-1:0] DIM_A = AW'(TEX_DIM);
  localparam int XMW   = 26;   // rounded coordinate magnitude bits
  localparam int DIV_LAST = 20;
  localparam int SUM_W = 26;   // colour sum over the in-use texture
  localparam int CNT_W = 18;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CROSS = 4'd1;
  localparam logic [3:0] S_SHIFT = 4'd2;
  localparam logic [3:0] S_SQR   = 4'd3;
  localparam logic [3:0] S_ROOT  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_BLEND = 4'd6;
  localparam logic [3:0] S_WRAP  = 4'd7;
  localparam logic [3:0] S_FIX   = 4'd8;
  localparam logic [3:0] S_READ  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_MEAN  = 4'd11;
  localparam logic [3:0] S_MDIV  = 4'd12;

  // configuration registers
  logic [VTX_W-1:0]  va_q, vb_q, vc_q;
  logic [CFG_W-1:0]  ta_q, tb_q, tc_q;
  logic [SIZE_W-1:0] tw_q, th_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
      vb_q <= '0;
      vc_q <= '0;
      ta_q <= '0;
      tb_q <= '0;
      tc_q <= '0;
      tw_q <= 9'd256;
      th_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VERTEX_A:   va_q <= cfg_wdata_i[VTX_W-1:0];
        REG_VERTEX_B:   vb_q <= cfg_wdata_i[VTX_W-1:0];
        REG_VERTEX_C:   vc_q <= cfg_wdata_i[VTX_W-1:0];
        REG_TEXCOORD_A: ta_q <= cfg_wdata_i;
        REG_TEXCOORD_B: tb_q <= cfg_wdata_i;
        REG_TEXCOORD_C: tc_q <= cfg_wdata_i;
        REG_TEX_WIDTH:  tw_q <= cfg_wdata_i[SIZE_W-1:0];
        REG_TEX_HEIGHT: th_q <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // size in use: zero counts as one, capped at the memory dimension
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) r = 9'd1;
    else if (int'(s) > TEX_DIM) r = SIZE_W'(TEX_DIM);
    else r = s;
    return r;
  endfunction

  // control state
  logic [3:0] state_q;
  logic [1:0] ci_q, cj_q, mi_q;
  logic       iss_done_q, pv_q, sqv_q, go_q, bv_q, miss_done_q, rv_q, out_valid_q;
  logic [1:0] sc_q;
  logic [4:0] dc_q, wc_q;
  logic [2:0] bc_q, mdc_q;
  logic [SIZE_W-1:0] mxc_q, myc_q;

  // datapath registers
  logic signed [COORD_W-1:0] px_q, py_q, pz_q;
  logic [SIZE_W-1:0] w_q, h_q, xi_q, yi_q, remx_q, remy_q;
  logic signed [43:0] p1_q, p2_q;
  logic [1:0]  pci_q, pcj_q;
  logic        nz_q, deg_q;
  logic signed [44:0] k_q [9];
  logic [44:0] mx_q, mxs_q;
  logic [3:0]  s_q;
  logic [59:0] sq_q;
  logic [ROOT_IN_W-1:0] acc_q;
  logic [ROOT_OUT_W-1:0] mag_q [3];
  logic [33:0] total_q, rem_q;
  logic [20:0] qt_q;
  logic [20:0] wt_q [3];
  logic signed [53:0] pu_q, pw_q;
  logic signed [55:0] su_q, sv_q;
  logic signed [63:0] xs_q, ys_q;
  logic [XMW-1:0] xsh_q, ysh_q;
  logic        xneg_q, yneg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] sr_q, sg_q, sb_q;
  logic [24:0] cs_q;
  logic [7:0]  qr_q, qg_q, qb_q;
  logic [7:0]  ro_q, go_out_q, bo_q;
  logic        dego_q;

  // memory and root unit hookup
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [TEXEL_W-1:0] mem_rdata;
  root_stat_t         root_stat;
  logic [ROOT_OUT_W-1:0] root_res;

  logic in_fire, out_free;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign mem_we = in_fire && (op_i == OP_WRITE) && (int'(texel_col_i) < TEX_DIM) &&
                  (int'(texel_row_i) < TEX_DIM);
  assign mem_waddr = AW'(texel_row_i) * DIM_A + AW'(texel_col_i);
  assign mem_re    = (state_q == S_READ) || (state_q == S_MEAN && !miss_done_q);
  assign mem_raddr = (state_q == S_READ) ? AW'(yi_q) * DIM_A + AW'(xi_q)
                                         : AW'(myc_q) * DIM_A + AW'(mxc_q);

  bts_texmem #(.Depth(Depth), .AddrW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i ({blue_in_i, green_in_i, red_in_i}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bts_isqrt u_root (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (go_q),
    .radicand_i (acc_q),
    .stat_o     (root_stat),
    .root_o     (root_res)
  );

  // edge vectors and point-relative corner vectors
  logic signed [21:0] e1 [3], e2 [3], da [3], db [3], dc [3];
  logic signed [21:0] lv [3], rv [3];
  logic signed [21:0] x1, y1, x2, y2;
  logic signed [COORD_W-1:0] pp [3];

  always_comb begin
    pp[0] = px_q;
    pp[1] = py_q;
    pp[2] = pz_q;
    for (int j = 0; j < 3; j++) begin
      e1[j] = 22'(vtx_comp(vb_q, 2'(j))) - 22'(vtx_comp(va_q, 2'(j)));
      e2[j] = 22'(vtx_comp(vc_q, 2'(j))) - 22'(vtx_comp(va_q, 2'(j)));
      da[j] = 22'(vtx_comp(va_q, 2'(j))) - 22'(pp[j]);
      db[j] = 22'(vtx_comp(vb_q, 2'(j))) - 22'(pp[j]);
      dc[j] = 22'(vtx_comp(vc_q, 2'(j))) - 22'(pp[j]);
    end
    // normal, then the three sub-triangle cross products
    for (int j = 0; j < 3; j++) begin
      case (ci_q)
        2'd0: begin lv[j] = e1[j]; rv[j] = e2[j]; end
        2'd1: begin lv[j] = db[j]; rv[j] = dc[j]; end
        2'd2: begin lv[j] = dc[j]; rv[j] = da[j]; end
        default: begin lv[j] = da[j]; rv[j] = db[j]; end
      endcase
    end
    case (cj_q)
      2'd0: begin x1 = lv[1]; y1 = rv[2]; x2 = lv[2]; y2 = rv[1]; end
      2'd1: begin x1 = lv[2]; y1 = rv[0]; x2 = lv[0]; y2 = rv[2]; end
      default: begin x1 = lv[0]; y1 = rv[1]; x2 = lv[1]; y2 = rv[0]; end
    endcase
  end

  logic signed [44:0] diff;
  logic [44:0] absd;
  logic [3:0]  kw_idx, kr_idx;
  logic signed [44:0] kr;
  logic [44:0] absk, shk;
  assign diff   = 45'(p1_q) - 45'(p2_q);
  assign absd   = diff[44] ? 45'(-diff) : 45'(diff);
  assign kw_idx = 4'(pci_q - 2'd1) * 4'd3 + 4'(pcj_q);
  assign kr_idx = 4'(mi_q) * 4'd3 + 4'(sc_q);
  assign kr     = k_q[kr_idx];
  assign absk   = kr[44] ? 45'(-kr) : 45'(kr);
  assign shk    = absk >> s_q;

  // weight division step
  logic [34:0] dv_r2;
  logic [33:0] dv_mag;
  logic        dv_ge;
  logic [33:0] dv_rem;
  logic [20:0] dv_qt;
  always_comb begin
    dv_mag = 34'(mag_q[mi_q]);
    dv_r2  = {rem_q, 1'b0};
    if (dc_q == '0) begin
      dv_ge  = dv_mag >= total_q;
      dv_rem = dv_ge ? dv_mag - total_q : dv_mag;
      dv_qt  = {20'd0, dv_ge};
    end else begin
      dv_ge  = dv_r2 >= 35'(total_q);
      dv_rem = dv_ge ? 34'(dv_r2 - 35'(total_q)) : 34'(dv_r2);
      dv_qt  = {qt_q[19:0], dv_ge};
    end
  end

  // blend operands
  logic signed [TC_W-1:0] tu, tv;
  logic [CFG_W-1:0] tsel;
  always_comb begin
    case (bc_q)
      3'd0:    tsel = ta_q;
      3'd1:    tsel = tb_q;
      default: tsel = tc_q;
    endcase
    tu = tsel[31:0];
    tv = tsel[63:32];
  end
  logic signed [21:0] wts;
  assign wts = $signed({1'b0, wt_q[bc_q[1:0]]});

  // rounding half away from zero of the 36-fraction-bit products
  logic [63:0] xabs, yabs, xrnd, yrnd;
  assign xabs = xs_q[63] ? 64'(-xs_q) : 64'(xs_q);
  assign yabs = ys_q[63] ? 64'(-ys_q) : 64'(ys_q);
  assign xrnd = xabs + 64'h8_0000_0000;
  assign yrnd = yabs + 64'h8_0000_0000;

  // wrap remainder step
  logic [SIZE_W:0] rx, ry;
  assign rx = {remx_q, xsh_q[XMW-1]};
  assign ry = {remy_q, ysh_q[XMW-1]};

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ci_q        <= '0;
      cj_q        <= '0;
      mi_q        <= '0;
      iss_done_q  <= 1'b0;
      pv_q        <= 1'b0;
      sqv_q       <= 1'b0;
      go_q        <= 1'b0;
      bv_q        <= 1'b0;
      miss_done_q <= 1'b0;
      rv_q        <= 1'b0;
      sc_q        <= '0;
      dc_q        <= '0;
      wc_q        <= '0;
      bc_q        <= '0;
      mdc_q       <= '0;
      mxc_q       <= '0;
      myc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire && op_i == OP_QUERY) begin
            state_q    <= S_CROSS;
            ci_q       <= '0;
            cj_q       <= '0;
            iss_done_q <= 1'b0;
            pv_q       <= 1'b0;
          end
        end
        S_CROSS: begin
          pv_q <= !iss_done_q;
          if (!iss_done_q) begin
            if (cj_q == 2'd2) begin
              cj_q <= '0;
              if (ci_q == 2'd3) iss_done_q <= 1'b1;
              else ci_q <= ci_q + 2'd1;
            end else begin
              cj_q <= cj_q + 2'd1;
            end
          end else if (!pv_q) begin
            state_q     <= nz_q ? S_SHIFT : S_MEAN;
            mxc_q       <= '0;
            myc_q       <= '0;
            miss_done_q <= 1'b0;
            rv_q        <= 1'b0;
          end
        end
        S_SHIFT: begin
          if (mxs_q[44:30] == '0) begin
            state_q <= S_SQR;
            mi_q    <= '0;
            sc_q    <= '0;
            sqv_q   <= 1'b0;
          end
        end
        S_SQR: begin
          sqv_q <= (sc_q != 2'd3);
          if (sc_q == 2'd3) begin
            state_q <= S_ROOT;
            go_q    <= 1'b1;
            sc_q    <= '0;
          end else begin
            sc_q <= sc_q + 2'd1;
          end
        end
        S_ROOT: begin
          go_q <= 1'b0;
          if (root_stat.done) begin
            sqv_q <= 1'b0;
            if (mi_q == 2'd2) begin
              state_q <= S_DIV;
              mi_q    <= '0;
              dc_q    <= '0;
            end else begin
              state_q <= S_SQR;
              mi_q    <= mi_q + 2'd1;
            end
          end
        end
        S_DIV: begin
          if (dc_q == 5'(DIV_LAST)) begin
            dc_q <= '0;
            if (mi_q == 2'd2) begin
              state_q <= S_BLEND;
              bc_q    <= '0;
              bv_q    <= 1'b0;
            end else begin
              mi_q <= mi_q + 2'd1;
            end
          end else begin
            dc_q <= dc_q + 5'd1;
          end
        end
        S_BLEND: begin
          bv_q <= (bc_q < 3'd3);
          if (bc_q == 3'd5) begin
            state_q <= S_WRAP;
            wc_q    <= '0;
          end else begin
            bc_q <= bc_q + 3'd1;
          end
        end
        S_WRAP: begin
          if (wc_q == 5'(XMW - 1)) state_q <= S_FIX;
          else wc_q <= wc_q + 5'd1;
        end
        S_FIX:  state_q <= S_READ;
        S_READ: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) state_q <= S_IDLE;
        end
        S_MEAN: begin
          rv_q <= !miss_done_q;
          if (!miss_done_q) begin
            if (mxc_q == w_q - 9'd1) begin
              mxc_q <= '0;
              if (myc_q == h_q - 9'd1) miss_done_q <= 1'b1;
              else myc_q <= myc_q + 9'd1;
            end else begin
              mxc_q <= mxc_q + 9'd1;
            end
          end else if (!rv_q) begin
            state_q <= S_MDIV;
            mdc_q   <= '0;
          end
        end
        S_MDIV: begin
          if (mdc_q == 3'd7) state_q <= S_OUT;
          else mdc_q <= mdc_q + 3'd1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          px_q <= point_x_i;
          py_q <= point_y_i;
          pz_q <= point_z_i;
          w_q  <= clamp_size(tw_q);
          h_q  <= clamp_size(th_q);
          nz_q <= 1'b0;
          mx_q <= '0;
        end
      end
      S_CROSS: begin
        p1_q  <= x1 * y1;
        p2_q  <= x2 * y2;
        pci_q <= ci_q;
        pcj_q <= cj_q;
        if (pv_q) begin
          if (pci_q == 2'd0) begin
            if (diff != '0) nz_q <= 1'b1;
          end else begin
            k_q[kw_idx] <= diff;
            if (absd > mx_q) mx_q <= absd;
          end
        end
        mxs_q <= mx_q;
        s_q   <= '0;
        deg_q <= !nz_q;
        cnt_q <= CNT_W'(w_q) * CNT_W'(h_q);
        sr_q  <= '0;
        sg_q  <= '0;
        sb_q  <= '0;
        acc_q <= '0;
      end
      S_SHIFT: begin
        if (mxs_q[44:30] != '0) begin
          mxs_q <= mxs_q >> 1;
          s_q   <= s_q + 4'd1;
        end
      end
      S_SQR: begin
        sq_q  <= shk[29:0] * shk[29:0];
        acc_q <= acc_q + (sqv_q ? ROOT_IN_W'(sq_q) : '0);
      end
      S_ROOT: begin
        if (root_stat.done) begin
          mag_q[mi_q] <= root_res;
          acc_q       <= '0;
          total_q     <= 34'(mag_q[0]) + 34'(mag_q[1]) + 34'(root_res);
        end
      end
      S_DIV: begin
        rem_q <= dv_rem;
        qt_q  <= dv_qt;
        if (dc_q == 5'(DIV_LAST)) begin
          wt_q[mi_q] <= (total_q == '0) ? '0 : dv_qt;
        end
        su_q <= '0;
        sv_q <= '0;
      end
      S_BLEND: begin
        pu_q <= tu * wts;
        pw_q <= tv * wts;
        if (bv_q) begin
          su_q <= su_q + 56'(pu_q);
          sv_q <= sv_q + 56'(pw_q);
        end
        if (bc_q == 3'd4) begin
          xs_q <= 64'(su_q * $signed({1'b0, w_q}));
          ys_q <= 64'(sv_q * $signed({1'b0, h_q}));
        end
        xsh_q  <= xrnd[35+XMW:36];
        ysh_q  <= yrnd[35+XMW:36];
        xneg_q <= xs_q[63];
        yneg_q <= ys_q[63];
        remx_q <= '0;
        remy_q <= '0;
      end
      S_WRAP: begin
        remx_q <= (rx >= {1'b0, w_q}) ? SIZE_W'(rx - {1'b0, w_q}) : rx[SIZE_W-1:0];
        remy_q <= (ry >= {1'b0, h_q}) ? SIZE_W'(ry - {1'b0, h_q}) : ry[SIZE_W-1:0];
        xsh_q  <= xsh_q << 1;
        ysh_q  <= ysh_q << 1;
      end
      S_FIX: begin
        // negative coordinates fold back into the texture
        xi_q <= (xneg_q && remx_q != '0) ? w_q - remx_q : remx_q;
        yi_q <= (yneg_q && remy_q != '0) ? h_q - remy_q : remy_q;
      end
      S_MEAN: begin
        if (rv_q) begin
          sr_q <= sr_q + SUM_W'(mem_rdata[7:0]);
          sg_q <= sg_q + SUM_W'(mem_rdata[15:8]);
          sb_q <= sb_q + SUM_W'(mem_rdata[23:16]);
        end
        cs_q <= {cnt_q, 7'd0};
        qr_q <= '0;
        qg_q <= '0;
        qb_q <= '0;
      end
      S_MDIV: begin
        // quotient is below 256, so eight restoring steps suffice
        if (sr_q >= SUM_W'(cs_q)) sr_q <= sr_q - SUM_W'(cs_q);
        if (sg_q >= SUM_W'(cs_q)) sg_q <= sg_q - SUM_W'(cs_q);
        if (sb_q >= SUM_W'(cs_q)) sb_q <= sb_q - SUM_W'(cs_q);
        qr_q <= {qr_q[6:0], sr_q >= SUM_W'(cs_q)};
        qg_q <= {qg_q[6:0], sg_q >= SUM_W'(cs_q)};
        qb_q <= {qb_q[6:0], sb_q >= SUM_W'(cs_q)};
        cs_q <= cs_q >> 1;
      end
      S_OUT: begin
        if (out_free) begin
          ro_q     <= deg_q ? qr_q : mem_rdata[7:0];
          go_out_q <= deg_q ? qg_q : mem_rdata[15:8];
          bo_q     <= deg_q ? qb_q : mem_rdata[23:16];
          dego_q   <= deg_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = ro_q;
  assign green_out_o  = go_out_q;
  assign blue_out_o   = bo_q;
  assign degenerate_o = dego_q;

  // the root unit only runs while the sequencer waits on it
  a_root_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_stat.busy |-> state_q == S_ROOT)
    else $error("root unit busy outside root phase");

  // texel writes only land while no query is in flight
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == S_IDLE)
    else $error("texel write during query");

  // wrapped coordinates stay inside the in-use texture
  a_wrap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> (xi_q < w_q) && (yi_q < h_q))
    else $error("wrapped texel coordinate out of range");

  // a finished query always hands an output beat over
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> out_valid_o && state_q == S_IDLE)
    else $error("query result not presented");

endmodule
